[rtl/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tag;
        logic [30:0] total_size;
        logic [30:0] done_size;
    } spq_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_tag;
        logic [30:0] out_total;
        logic [30:0] out_done;
        logic [4:0]  occupancy;
    } spq_rsp_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [30:0] total;
        logic [30:0] done;
    } spq_entry_t;

    typedef struct packed {
        logic accept;
        logic search_step;
        logic shift_step;
        logic write_entry;
        logic pop_read;
        logic load_out;
    } spq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic search_end;
        logic shift_done;
        logic out_free;
    } spq_stat_t;

endpackage

`default_nettype wire

[rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: controller, datapath and checks.
//
// The request channel (req_valid, req_stall, req) carries one word per
// operation: append at the tail, insert ordered by remaining size
// (total minus done), or pop the head. The response channel (rsp_valid,
// rsp_stall, rsp) returns exactly one word per request with a status code,
// the popped entry's fields (zero unless a pop succeeded) and the occupancy
// after the operation.
// One request is worked on at a time; req_stall is high from acceptance
// until its response word has been loaded into the output register.
// After acceptance an append passes through S_WRITE and a pop through S_POP
// before S_DONE loads the response word; a rejected or unused operation goes
// straight to S_DONE. An ordered insert into a non-empty queue first searches
// for its place, then shifts the entries from there one place toward the tail,
// then writes in S_WRITE. The next request can be taken once the controller is
// back in S_IDLE after the load. The search and the shift walk the entry memory
// one entry per cycle through its single read and single write port.
// Reset clears count and head at once; the entry memory is left as it is.
// A stalled response word stays in the output register unchanged; the block
// takes and works the next request meanwhile but holds that one's result in S_DONE until it frees.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire spq_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output spq_rsp_t      rsp
);

    spq_cmd_t  cmd;
    spq_stat_t stat;

    // Sequencing lives in the controller; storage and arithmetic in the datapath.
    spq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .stat      (stat),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    // An accepted request keeps the request side closed in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request side open right after an accepted word");

    // The output register is loaded only when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid || !rsp_stall))
        else $error("response word overwritten while stalled");

    // A rejected operation returns zero entry fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |->
            (rsp.out_tag == 16'd0 && rsp.out_total == 31'd0 && rsp.out_done == 31'd0))
        else $error("entry fields nonzero on a rejected operation");

    // An empty-queue pop reports zero occupancy; a full-queue push reports the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.occupancy == 5'd0))
        else $error("empty status with nonzero occupancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_FULL) |-> (rsp.occupancy == 5'(QUEUE_DEPTH)))
        else $error("full status with occupancy other than the depth");

endmodule

`default_nettype wire

[rtl/spq_datapath.sv]
// Datapath of the sorted priority queue: entry memory, pointers, compare and output register.
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire spq_req_t  req,
    input  wire spq_cmd_t  cmd,
    output spq_stat_t      stat,
    output spq_rsp_t       rsp,
    output logic           rsp_valid,
    input  wire logic      rsp_stall
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    // Logical position (from the head) to memory address, wrapping at the depth.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [IDX_W-1:0] offs);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[IDX_W-1:0];
    endfunction

    spq_entry_t mem [QUEUE_DEPTH];

    spq_entry_t        rd_data_reg;
    logic              rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  cidx_reg, cidx_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic              issue_reg, issue_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    spq_req_t          item_reg, item_next;
    logic [1:0]        status_reg, status_next;
    logic              pop_reg, pop_next;
    spq_rsp_t          rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    spq_entry_t        mem_wdata;

    logic signed [31:0] want, rem;
    logic               found, last;
    logic [CNT_W+4:0]   occ_wide;

    assign want  = $signed({1'b0, item_reg.total_size}) - $signed({1'b0, item_reg.done_size});
    assign rem   = $signed({1'b0, rd_data_reg.total}) - $signed({1'b0, rd_data_reg.done});
    // The head is passed when not larger; later entries only when strictly smaller.
    assign found = rd_valid_reg && ((cidx_reg == '0) ? (want < rem) : (rem >= want));
    assign last  = rd_valid_reg && ((CNT_W'(cidx_reg) + CNT_W'(1)) == count_reg);
    assign occ_wide = (CNT_W + 5)'(count_reg);

    assign stat.full       = (count_reg >= DEPTH_C);
    assign stat.empty      = (count_reg == '0);
    assign stat.search_end = found || last;
    assign stat.shift_done = !issue_reg && !rd_valid_reg;
    assign stat.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        logic [IDX_W-1:0] pos_v;
        pos_v          = found ? cidx_reg : count_reg[IDX_W-1:0];
        rd_valid_next  = rd_valid_reg;
        idx_next       = idx_reg;
        cidx_next      = cidx_reg;
        pos_next       = pos_reg;
        issue_next     = issue_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        item_next      = item_reg;
        status_next    = status_reg;
        pop_next       = pop_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = phys(head_reg, pos_reg);
        mem_wdata      = '{tag: item_reg.tag, total: item_reg.total_size,
                           done: item_reg.done_size};
        mem_re         = 1'b0;
        mem_raddr      = phys(head_reg, idx_reg);

        if (cmd.accept)
        begin
            item_next     = req;
            pop_next      = 1'b0;
            pos_next      = count_reg[IDX_W-1:0];
            idx_next      = '0;
            rd_valid_next = 1'b0;
            priority if ((req.kind == KIND_APPEND || req.kind == KIND_INSERT) && stat.full)
            begin
                status_next = ST_FULL;
            end
            else if (req.kind == KIND_POP && stat.empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_OK;
            end
        end

        if (cmd.search_step)
        begin
            if (stat.search_end)
            begin
                pos_next      = pos_v;
                idx_next      = IDX_W'(count_reg - CNT_W'(1));
                issue_next    = (count_reg > CNT_W'(pos_v));
                rd_valid_next = 1'b0;
            end
            else if (CNT_W'(idx_reg) < count_reg)
            begin
                mem_re        = 1'b1;
                rd_valid_next = 1'b1;
                cidx_next     = idx_reg;
                idx_next      = idx_reg + IDX_W'(1);
            end
            else
            begin
                rd_valid_next = 1'b0;
            end
        end

        if (cmd.shift_step)
        begin
            // Read one entry toward the head while writing the previous one a place up.
            if (rd_valid_reg)
            begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, cidx_reg + IDX_W'(1));
                mem_wdata = rd_data_reg;
            end
            if (issue_reg)
            begin
                mem_re        = 1'b1;
                rd_valid_next = 1'b1;
                cidx_next     = idx_reg;
                if (idx_reg == pos_reg)
                begin
                    issue_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            else
            begin
                rd_valid_next = 1'b0;
            end
        end

        if (cmd.write_entry)
        begin
            mem_we     = 1'b1;
            count_next = count_reg + CNT_W'(1);
        end

        if (cmd.pop_read)
        begin
            mem_re     = 1'b1;
            mem_raddr  = head_reg;
            head_next  = phys(head_reg, IDX_W'(1));
            count_next = count_reg - CNT_W'(1);
            pop_next   = 1'b1;
        end

        if (cmd.load_out)
        begin
            rsp_next.status    = status_reg;
            rsp_next.out_tag   = pop_reg ? rd_data_reg.tag : 16'd0;
            rsp_next.out_total = pop_reg ? rd_data_reg.total : 31'd0;
            rsp_next.out_done  = pop_reg ? rd_data_reg.done : 31'd0;
            rsp_next.occupancy = occ_wide[4:0];
            rsp_valid_next     = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            issue_reg     <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_valid_next;
            issue_reg     <= issue_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cidx_reg   <= cidx_next;
        pos_reg    <= pos_next;
        item_reg   <= item_next;
        status_reg <= status_next;
        pop_reg    <= pop_next;
        rsp_reg    <= rsp_next;
    end

endmodule

`default_nettype wire

[rtl/spq_controller.sv]
// Controller state machine of the sorted priority queue.
`default_nettype none

module spq_controller
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    input  wire logic [1:0] req_kind,
    input  wire spq_stat_t  stat,
    output spq_cmd_t        cmd,
    output logic            req_stall
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_WRITE  = 6'b001000,
        S_POP    = 6'b010000,
        S_DONE   = 6'b100000
    } spq_state_t;

    spq_state_t state_reg, state_next;

    assign req_stall       = (state_reg != S_IDLE);
    assign cmd.accept      = (state_reg == S_IDLE) && req_valid;
    assign cmd.search_step = (state_reg == S_SEARCH);
    assign cmd.shift_step  = (state_reg == S_SHIFT);
    assign cmd.write_entry = (state_reg == S_WRITE);
    assign cmd.pop_read    = (state_reg == S_POP);
    assign cmd.load_out    = (state_reg == S_DONE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_kind)
                        KIND_APPEND, KIND_INSERT:
                        begin
                            priority if (stat.full)
                                state_next = S_DONE;
                            else if (req_kind == KIND_APPEND || stat.empty)
                                state_next = S_WRITE;
                            else
                                state_next = S_SEARCH;
                        end
                        KIND_POP:
                            state_next = stat.empty ? S_DONE : S_POP;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (stat.search_end)
                    state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                    state_next = S_WRITE;
            end
            S_WRITE:
                state_next = S_DONE;
            S_POP:
                state_next = S_DONE;
            S_DONE:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire
